[rtl/rpic_pkg.sv]
// ----------------------------------------------------------------------------
// rpic_pkg
// Types and codes for the rotating priority interrupt controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rpic_pkg;

  localparam int unsigned NumLines = 8;
  localparam int unsigned LvlW     = $clog2(NumLines);

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_RAISE = 3'd2,
    CMD_LOWER = 3'd3,
    CMD_ACK   = 3'd4
  } cmd_e;

  // OCW2 command types, bits 7..5
  typedef enum logic [2:0] {
    EOI_NONSPEC     = 3'd1,
    EOI_SPEC        = 3'd3,
    EOI_ROT_NONSPEC = 3'd5,
    EOI_ROT_SPEC    = 3'd7
  } eoi_e;

  // initialization steps
  localparam logic [1:0] InitIcw2 = 2'd1;
  localparam logic [1:0] InitIcw3 = 2'd2;
  localparam logic [1:0] InitIcw4 = 2'd3;

  localparam logic [7:0] MaskReset   = 8'hFF;
  localparam logic [7:0] OffsetReset = 8'h08;
  localparam logic [7:0] OffsetMask  = 8'hF8;
  localparam int unsigned Icw1Bit    = 4;
  localparam int unsigned Ocw3Bit    = 3;
  localparam int unsigned RrBit      = 1;  // OCW3 read-register enable
  localparam int unsigned RisBit     = 0;  // OCW3 select ISR
  localparam int unsigned SnglBit    = 1;  // ICW1 single mode
  localparam int unsigned Ic4Bit     = 0;  // ICW1 ICW4 needed

  typedef struct packed {
    logic [2:0] cmd;
    logic       reg_addr;
    logic [7:0] write_data;
    logic [2:0] line_num;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       vector_valid;
    logic [7:0] vector;
    logic       int_request;
  } out_word_t;

  typedef struct packed {
    logic            found;
    logic [LvlW-1:0] lvl;
  } scan_t;

endpackage

`default_nettype wire

[rtl/rotating_priority_interrupt_controller.sv]
// ----------------------------------------------------------------------------
// rotating_priority_interrupt_controller
// Eight-line interrupt controller with rotating priority and EOI handling.
// ----------------------------------------------------------------------------
// Datapath: input register, then result register; the state update and
// priority scan sit between them.
// Throughput: one word per cycle while the output is not stalled.
// Reset: asynchronous; mask all set, vector base 0x08, all other state clear.
`default_nettype none

module rotating_priority_interrupt_controller
  import rpic_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o
);

  // Rotating scan: the level just above lowest ranks first. With blk set,
  // an in-service level met before any pending one stops the search.
  function automatic scan_t rot_scan(input logic [NumLines-1:0] pend,
                                     input logic [NumLines-1:0] svc,
                                     input logic [LvlW-1:0]     lowest,
                                     input logic                blk);
    scan_t           res;
    logic            done;
    logic [LvlW-1:0] lvl;
    res  = '0;
    done = 1'b0;
    for (int i = 0; i < NumLines; i++) begin
      lvl = lowest + LvlW'(i + 1);
      if (!done) begin
        if (svc[lvl]) begin
          done      = 1'b1;
          res.found = !blk;
          res.lvl   = lvl;
        end else if (pend[lvl] && blk) begin
          done      = 1'b1;
          res.found = 1'b1;
          res.lvl   = lvl;
        end
      end
    end
    return res;
  endfunction

  logic            in_valid_q;
  in_word_t        in_q;
  logic            out_valid_q;
  out_word_t       out_q, out_d;
  logic            advance, fire;

  logic [7:0]      req_q, req_d;
  logic [7:0]      svc_q, svc_d;
  logic [7:0]      mask_q, mask_d;
  logic [LvlW-1:0] low_q, low_d;
  logic            show_q, show_d;
  logic            init_q, init_d;
  logic [1:0]      step_q, step_d;
  logic [7:0]      icw1_q, icw1_d;
  logic [7:0]      offs_q, offs_d;

  scan_t           grant, top_svc, grant_after;
  logic [7:0]      wd;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign wd          = in_q.write_data;

  assign grant   = rot_scan(req_q & ~mask_q, svc_q, low_q, 1'b1);
  assign top_svc = rot_scan('0, svc_q, low_q, 1'b0);

  always_comb begin
    req_d  = req_q;
    svc_d  = svc_q;
    mask_d = mask_q;
    low_d  = low_q;
    show_d = show_q;
    init_d = init_q;
    step_d = step_q;
    icw1_d = icw1_q;
    offs_d = offs_q;
    out_d  = '0;
    unique case (in_q.cmd)
      CMD_WRITE: begin
        if (!in_q.reg_addr) begin
          if (wd[Icw1Bit]) begin
            icw1_d = wd;
            step_d = InitIcw2;
            init_d = 1'b1;
            mask_d = '0;
            svc_d  = '0;
            req_d  = '0;
            show_d = 1'b0;
            low_d  = '1;
          end else if (wd[Ocw3Bit]) begin
            if (wd[RrBit]) show_d = wd[RisBit];
          end else begin
            case (wd[7:5])
              EOI_NONSPEC, EOI_ROT_NONSPEC: begin
                if (top_svc.found) begin
                  svc_d[top_svc.lvl] = 1'b0;
                  if (wd[7:5] == EOI_ROT_NONSPEC) low_d = top_svc.lvl;
                end
              end
              EOI_SPEC: svc_d[wd[LvlW-1:0]] = 1'b0;
              EOI_ROT_SPEC: begin
                svc_d[wd[LvlW-1:0]] = 1'b0;
                low_d               = wd[LvlW-1:0];
              end
              default: ;
            endcase
          end
        end else if (!init_q) begin
          mask_d = wd;
        end else begin
          case (step_q)
            InitIcw2: begin
              offs_d = wd & OffsetMask;
              if (!icw1_q[SnglBit])   step_d = InitIcw3;
              else if (icw1_q[Ic4Bit]) step_d = InitIcw4;
              else                     init_d = 1'b0;
            end
            InitIcw3: begin
              if (icw1_q[Ic4Bit]) step_d = InitIcw4;
              else                init_d = 1'b0;
            end
            default: init_d = 1'b0;
          endcase
        end
      end
      CMD_READ: begin
        if (!in_q.reg_addr) out_d.read_data = show_q ? svc_q : req_q;
        else                out_d.read_data = mask_q;
      end
      CMD_RAISE: req_d[in_q.line_num] = 1'b1;
      CMD_LOWER: req_d[in_q.line_num] = 1'b0;
      CMD_ACK: begin
        if (grant.found) begin
          req_d[grant.lvl]   = 1'b0;
          svc_d[grant.lvl]   = 1'b1;
          out_d.vector_valid = 1'b1;
          out_d.vector       = offs_q + 8'(grant.lvl);
        end
      end
      default: ;
    endcase
    grant_after       = rot_scan(req_d & ~mask_d, svc_d, low_d, 1'b1);
    out_d.int_request = grant_after.found;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      svc_q       <= '0;
      mask_q      <= MaskReset;
      low_q       <= '0;
      show_q      <= 1'b0;
      init_q      <= 1'b0;
      step_q      <= '0;
      icw1_q      <= '0;
      offs_q      <= OffsetReset;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance)    out_valid_q <= in_valid_q;
      if (fire) begin
        req_q  <= req_d;
        svc_q  <= svc_d;
        mask_q <= mask_d;
        low_q  <= low_d;
        show_q <= show_d;
        init_q <= init_d;
        step_q <= step_d;
        icw1_q <= icw1_d;
        offs_q <= offs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_word_i;
    if (fire) out_q <= out_d;
  end

  a_offs_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offs_q[2:0] == 3'd0)
    else $error("vector base lost its alignment");

  a_grant_in_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.cmd == CMD_ACK && grant.found |=> svc_q[$past(grant.lvl)])
    else $error("granted level not marked in service");

  a_no_vec_without_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.vector_valid |-> out_q.vector == 8'd0)
    else $error("vector driven without a grant");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire
